// ===== rtl/ssi_pkg.sv =====
package ssi_pkg;

   // Coordinates keep this many low bits of each 16-bit field, sign-extended.
   localparam int COORD_BITS = 16;
   // Fraction bits of the crossing point.
   localparam int FRAC_BITS  = 8;

   localparam int FIELD_W = 16;
   localparam int OUT_W   = 24;

   localparam int CW  = COORD_BITS;
   localparam int DW  = CW + 1;              // coordinate differences
   localparam int PW  = 2 * DW + 1;          // denominator and numerators
   localparam int NW  = PW + DW + 1;         // point numerator
   localparam int QB  = CW + FRAC_BITS;      // quotient bits
   localparam int NSW = NW + FRAC_BITS;      // scaled point numerator

   localparam int FRONT_STAGES = 6;
   localparam int LATENCY      = FRONT_STAGES + QB + 1;

   typedef struct packed {
      logic signed [FIELD_W-1:0] a_start_x;
      logic signed [FIELD_W-1:0] a_start_y;
      logic signed [FIELD_W-1:0] a_end_x;
      logic signed [FIELD_W-1:0] a_end_y;
      logic signed [FIELD_W-1:0] b_start_x;
      logic signed [FIELD_W-1:0] b_start_y;
      logic signed [FIELD_W-1:0] b_end_x;
      logic signed [FIELD_W-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic signed [OUT_W-1:0] cross_x;
      logic signed [OUT_W-1:0] cross_y;
   } rsp_type;

   // One operand set for the divider pipeline. low holds the dividend bits
   // still to be brought in and, as they leave, the quotient bits.
   typedef struct packed {
      logic          valid;
      logic          hit;
      logic          neg;
      logic [PW-1:0] rem;
      logic [QB-1:0] low;
      logic [PW-1:0] den;
   } div_type;

endpackage

// ===== rtl/segment_segment_intersection_top.sv =====
// Segment intersection pipeline. Each transaction carries two segments with
// signed integer endpoints; the block reports whether they cross or touch and,
// on a hit, the crossing point in Q16.8, truncated toward zero (zero on a
// miss, and a parallel or degenerate pair is always a miss). A new
// transaction is taken in every clock cycle: busy stays low, so start alone
// launches one. The result of each transaction appears on rsp_data with
// rsp_valid high for exactly one cycle, in the same order as the
// transactions went in. The path runs through the setup stages (differences,
// cross products, sign normalization, range test, point numerators,
// scaling), then a 24-stage divider that retires one quotient bit per stage,
// then the output register. The receiver cannot stall the block, so it
// must take every result in the cycle it is offered.
module segment_segment_intersection_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ssi_pkg::req_type req_data,
   output logic             rsp_valid,
   output ssi_pkg::rsp_type rsp_data
);

   localparam int QB    = ssi_pkg::QB;
   localparam int OUT_W = ssi_pkg::OUT_W;

   ssi_pkg::div_type div_x_in, div_y_in, div_x_out, div_y_out;

   // The pipeline never stalls.
   assign busy = 1'b0;

   ssi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (start),
      .req_data  (req_data),
      .div_x     (div_x_in),
      .div_y     (div_y_in)
   );

   ssi_div u_div_x (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_x_in),
      .div_out (div_x_out)
   );

   ssi_div u_div_y (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_y_in),
      .div_out (div_y_out)
   );

   // Apply the sign to each quotient and force a miss to zero.
   logic             valid_ff, valid_in;
   ssi_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      logic signed [QB:0] vx, vy;
      vx = signed'({1'b0, div_x_out.low});
      vy = signed'({1'b0, div_y_out.low});
      if (div_x_out.neg) begin
         vx = -vx;
      end
      if (div_y_out.neg) begin
         vy = -vy;
      end
      valid_in       = div_x_out.valid;
      rsp_in.hit     = div_x_out.hit;
      rsp_in.cross_x = div_x_out.hit ? OUT_W'(vx) : '0;
      rsp_in.cross_y = div_x_out.hit ? OUT_W'(vy) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/ssi_front.sv =====
module ssi_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  ssi_pkg::req_type req_data,
   output ssi_pkg::div_type div_x,
   output ssi_pkg::div_type div_y
);

   localparam int CW  = ssi_pkg::CW;
   localparam int DW  = ssi_pkg::DW;
   localparam int PW  = ssi_pkg::PW;
   localparam int NW  = ssi_pkg::NW;
   localparam int QB  = ssi_pkg::QB;
   localparam int NSW = ssi_pkg::NSW;

   // Stage 1: differences.
   logic                 v1_ff, v1_in;
   logic signed [CW-1:0] ax1_ff, ay1_ff, ax1_in, ay1_in;
   logic signed [DW-1:0] rx1_ff, ry1_ff, ux1_ff, uy1_ff, wx1_ff, wy1_ff;
   logic signed [DW-1:0] rx1_in, ry1_in, ux1_in, uy1_in, wx1_in, wy1_in;

   always_comb begin
      logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      ax0 = CW'(req_data.a_start_x);
      ay0 = CW'(req_data.a_start_y);
      ax1 = CW'(req_data.a_end_x);
      ay1 = CW'(req_data.a_end_y);
      bx0 = CW'(req_data.b_start_x);
      by0 = CW'(req_data.b_start_y);
      bx1 = CW'(req_data.b_end_x);
      by1 = CW'(req_data.b_end_y);
      v1_in  = req_valid;
      ax1_in = ax0;
      ay1_in = ay0;
      rx1_in = DW'(ax1) - DW'(ax0);
      ry1_in = DW'(ay1) - DW'(ay0);
      ux1_in = DW'(bx1) - DW'(bx0);
      uy1_in = DW'(by1) - DW'(by0);
      wx1_in = DW'(ax0) - DW'(bx0);
      wy1_in = DW'(ay0) - DW'(by0);
   end

   // Stage 2: cross products.
   logic                 v2_ff, v2_in;
   logic signed [CW-1:0] ax2_ff, ay2_ff;
   logic signed [DW-1:0] rx2_ff, ry2_ff;
   logic signed [PW-1:0] d2_ff, sn2_ff, tn2_ff, d2_in, sn2_in, tn2_in;

   always_comb begin
      logic signed [2*DW-1:0] p0, p1, p2, p3, p4, p5;
      p0 = rx1_ff * uy1_ff;
      p1 = ux1_ff * ry1_ff;
      p2 = rx1_ff * wy1_ff;
      p3 = ry1_ff * wx1_ff;
      p4 = ux1_ff * wy1_ff;
      p5 = uy1_ff * wx1_ff;
      v2_in  = v1_ff;
      d2_in  = PW'(p0) - PW'(p1);
      sn2_in = PW'(p2) - PW'(p3);
      tn2_in = PW'(p4) - PW'(p5);
   end

   // Stage 3: make the denominator non-negative.
   logic                 v3_ff, v3_in;
   logic signed [CW-1:0] ax3_ff, ay3_ff;
   logic signed [DW-1:0] rx3_ff, ry3_ff;
   logic signed [PW-1:0] d3_ff, sn3_ff, tn3_ff, d3_in, sn3_in, tn3_in;

   always_comb begin
      v3_in = v2_ff;
      if (d2_ff[PW-1]) begin
         d3_in  = -d2_ff;
         sn3_in = -sn2_ff;
         tn3_in = -tn2_ff;
      end else begin
         d3_in  = d2_ff;
         sn3_in = sn2_ff;
         tn3_in = tn2_ff;
      end
   end

   // Stage 4: range test and the two point products per axis.
   logic                      v4_ff, v4_in, hit4_ff, hit4_in;
   logic signed [PW-1:0]      d4_ff;
   logic signed [CW+PW-1:0]   bx4_ff, by4_ff, bx4_in, by4_in;
   logic signed [PW+DW-1:0]   tx4_ff, ty4_ff, tx4_in, ty4_in;

   always_comb begin
      v4_in   = v3_ff;
      hit4_in = (d3_ff != '0) && !sn3_ff[PW-1] && (sn3_ff <= d3_ff)
                && !tn3_ff[PW-1] && (tn3_ff <= d3_ff);
      bx4_in  = ax3_ff * d3_ff;
      by4_in  = ay3_ff * d3_ff;
      tx4_in  = tn3_ff * rx3_ff;
      ty4_in  = tn3_ff * ry3_ff;
   end

   // Stage 5: point numerators.
   logic                 v5_ff, hit5_ff;
   logic signed [PW-1:0] d5_ff;
   logic signed [NW-1:0] nx5_ff, ny5_ff, nx5_in, ny5_in;

   always_comb begin
      nx5_in = NW'(bx4_ff) + NW'(tx4_ff);
      ny5_in = NW'(by4_ff) + NW'(ty4_ff);
   end

   // Stage 6: magnitude, scaling and split into divider operands.
   function automatic ssi_pkg::div_type prep(logic v, logic h,
                                             logic signed [NW-1:0] n,
                                             logic signed [PW-1:0] d);
      ssi_pkg::div_type r;
      logic [NW-1:0]    m;
      logic [NSW-1:0]   sh;
      r.valid = v;
      r.hit   = h;
      r.neg   = n[NW-1];
      m       = n[NW-1] ? NW'(-n) : NW'(n);
      sh      = NSW'(m) << ssi_pkg::FRAC_BITS;
      r.rem   = sh[QB+PW-1:QB];
      r.low   = sh[QB-1:0];
      r.den   = PW'(d);
      return r;
   endfunction

   ssi_pkg::div_type dx6_ff, dy6_ff, dx6_in, dy6_in;

   always_comb begin
      dx6_in = prep(v5_ff, hit5_ff, nx5_ff, d5_ff);
      dy6_in = prep(v5_ff, hit5_ff, ny5_ff, d5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dx6_ff.valid <= 1'b0;
         dy6_ff.valid <= 1'b0;
      end else begin
         dx6_ff <= dx6_in;
         dy6_ff <= dy6_in;
      end
   end

   always_ff @(posedge clock) begin
      ax1_ff <= ax1_in;  ay1_ff <= ay1_in;
      rx1_ff <= rx1_in;  ry1_ff <= ry1_in;
      ux1_ff <= ux1_in;  uy1_ff <= uy1_in;
      wx1_ff <= wx1_in;  wy1_ff <= wy1_in;

      ax2_ff <= ax1_ff;  ay2_ff <= ay1_ff;
      rx2_ff <= rx1_ff;  ry2_ff <= ry1_ff;
      d2_ff  <= d2_in;   sn2_ff <= sn2_in;  tn2_ff <= tn2_in;

      ax3_ff <= ax2_ff;  ay3_ff <= ay2_ff;
      rx3_ff <= rx2_ff;  ry3_ff <= ry2_ff;
      d3_ff  <= d3_in;   sn3_ff <= sn3_in;  tn3_ff <= tn3_in;

      hit4_ff <= hit4_in;
      d4_ff   <= d3_ff;
      bx4_ff  <= bx4_in;  by4_ff <= by4_in;
      tx4_ff  <= tx4_in;  ty4_ff <= ty4_in;

      hit5_ff <= hit4_ff;
      d5_ff   <= d4_ff;
      nx5_ff  <= nx5_in;  ny5_ff <= ny5_in;
   end

   assign div_x = dx6_ff;
   assign div_y = dy6_ff;

endmodule

// ===== rtl/ssi_div.sv =====
module ssi_div (
   input  logic             clock,
   input  logic             reset,
   input  ssi_pkg::div_type div_in,
   output ssi_pkg::div_type div_out
);

   localparam int PW = ssi_pkg::PW;
   localparam int QB = ssi_pkg::QB;

   // One restoring-division step per stage, one quotient bit each.
   ssi_pkg::div_type stg_ff [QB];
   ssi_pkg::div_type stg_in [QB];

   for (genvar i = 0; i < QB; i++) begin : g_stage
      ssi_pkg::div_type prev;
      assign prev = (i == 0) ? div_in : stg_ff[(i == 0) ? 0 : i - 1];

      always_comb begin
         logic [PW:0] rs;
         logic        qb;
         rs = {prev.rem, prev.low[QB-1]};
         qb = (rs >= {1'b0, prev.den});
         stg_in[i]     = prev;
         stg_in[i].rem = qb ? PW'(rs - {1'b0, prev.den}) : PW'(rs);
         stg_in[i].low = {prev.low[QB-2:0], qb};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[i].valid <= 1'b0;
         end else begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   assign div_out = stg_ff[QB-1];

endmodule

// ===== rtl/ssi_checker.sv =====
module ssi_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input ssi_pkg::rsp_type rsp_data
);

   // The block takes a transaction in every cycle.
   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // Every result comes from a transaction launched a fixed time earlier.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, ssi_pkg::LATENCY))
      else $error("result without matching transaction");

   // A miss carries a zero point.
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.cross_x == '0 && rsp_data.cross_y == '0))
      else $error("miss with nonzero point");

   // Reset flushes the pipeline.
   a_reset_flush : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind segment_segment_intersection_top ssi_checker u_ssi_checker (.*);
